[rtl/cnc_pkg.sv]
package cnc_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int COORD_BITS    = 32;
    localparam int OUT_SLOTS     = (MAX_NEIGHBORS > 16) ? 16 : MAX_NEIGHBORS;

    localparam int FIELD_W    = 32;
    localparam int TAG_W      = 31;
    localparam int SQ_W       = 64;
    localparam int SLOT_IDX_W = 4;
    localparam int OCNT_W     = $clog2(OUT_SLOTS + 1);

    localparam int S_TDATA_W = 224;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 136;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_SQ   = 1'b0,
        CFG_OUTPUT_MODE = 1'b1
    } cfg_index_t;

    // one candidate after the distance test
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic                      group;
        logic                      hit;
        logic [TAG_W-1:0]          tag;
        logic signed [FIELD_W-1:0] dx;
        logic signed [FIELD_W-1:0] dy;
        logic signed [FIELD_W-1:0] dz;
    } cand_res_t;

    // neighbor held in a collect cell
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [FIELD_W-1:0] dx;
        logic signed [FIELD_W-1:0] dy;
        logic signed [FIELD_W-1:0] dz;
    } nbr_entry_t;

    // formatted slot held in an output cell
    typedef struct packed {
        logic signed [FIELD_W-1:0] tag;
        logic signed [FIELD_W-1:0] dx;
        logic signed [FIELD_W-1:0] dy;
        logic signed [FIELD_W-1:0] dz;
    } slot_t;

    localparam slot_t EMPTY_SLOT = '{tag: -32'sd1, dx: '0, dy: '0, dz: '0};

    // collect cell status toward the top level and its right neighbor
    typedef struct packed {
        logic       occ;
        logic       occ_view;
        nbr_entry_t entry_view;
    } cell_view_t;

endpackage

[rtl/cnc_dist_pipe.sv]
module cnc_dist_pipe
    import cnc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_beat,
    input  logic signed [FIELD_W-1:0] center_x,
    input  logic signed [FIELD_W-1:0] center_y,
    input  logic signed [FIELD_W-1:0] center_z,
    input  logic signed [FIELD_W-1:0] cand_x,
    input  logic signed [FIELD_W-1:0] cand_y,
    input  logic signed [FIELD_W-1:0] cand_z,
    input  logic [TAG_W-1:0]          cand_tag,
    input  logic                      cand_valid,
    input  logic                      in_group,
    input  logic                      last_cand,
    input  logic [SQ_W-1:0]           cutoff_sq,
    output cand_res_t                 res
);

    localparam int DW = COORD_BITS + 1;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 group;
        logic                 cand;
        logic [TAG_W-1:0]     tag;
    } ctl_t;

    localparam logic signed [COORD_BITS-1:0] SAT_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] SAT_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

    // stage 1: exact deltas
    ctl_t                 c1_reg, c2_reg, c3_reg;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d1z_reg;
    logic signed [DW-1:0] d1x_next, d1y_next, d1z_next;
    // stage 2: squares and saturated deltas
    logic [SQ_W-1:0]      sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]      sqx_next, sqy_next, sqz_next;
    logic signed [FIELD_W-1:0] s2x_reg, s2y_reg, s2z_reg;
    logic signed [FIELD_W-1:0] s2x_next, s2y_next, s2z_next;
    // stage 3: partial sum
    logic [SQ_W-1:0]      sxy_reg, sz3_reg;
    logic [SQ_W-1:0]      sxy_next;
    logic signed [FIELD_W-1:0] s3x_reg, s3y_reg, s3z_reg;
    // stage 4: compare
    cand_res_t            res_reg, res_next;
    logic [SQ_W:0]        sum_a, sum_b;
    logic [SQ_W-1:0]      rsq;

    function automatic logic signed [DW-1:0] sext_coord(input logic [FIELD_W-1:0] v);
        return {v[COORD_BITS-1], v[COORD_BITS-1:0]};
    endfunction

    function automatic logic [SQ_W-1:0] square_mag(input logic signed [DW-1:0] d);
        logic [DW-1:0]           neg;
        logic [COORD_BITS-1:0]   mag;
        logic [2*COORD_BITS-1:0] prod;
        neg  = -d;
        mag  = d[DW-1] ? neg[COORD_BITS-1:0] : d[COORD_BITS-1:0];
        prod = mag * mag;
        return SQ_W'(prod);
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat_delta(input logic signed [DW-1:0] d);
        logic signed [COORD_BITS-1:0] s;
        if (d[DW-1] != d[DW-2]) begin
            s = d[DW-1] ? SAT_LO : SAT_HI;
        end else begin
            s = d[COORD_BITS-1:0];
        end
        return FIELD_W'(s);
    endfunction

    always_comb begin
        d1x_next = sext_coord(cand_x) - sext_coord(center_x);
        d1y_next = sext_coord(cand_y) - sext_coord(center_y);
        d1z_next = sext_coord(cand_z) - sext_coord(center_z);

        sqx_next = square_mag(d1x_reg);
        sqy_next = square_mag(d1y_reg);
        sqz_next = square_mag(d1z_reg);
        s2x_next = sat_delta(d1x_reg);
        s2y_next = sat_delta(d1y_reg);
        s2z_next = sat_delta(d1z_reg);

        sum_a    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        sxy_next = sum_a[SQ_W] ? {SQ_W{1'b1}} : sum_a[SQ_W-1:0];

        sum_b    = {1'b0, sxy_reg} + {1'b0, sz3_reg};
        rsq      = sum_b[SQ_W] ? {SQ_W{1'b1}} : sum_b[SQ_W-1:0];

        res_next.valid = c3_reg.valid;
        res_next.last  = c3_reg.last;
        res_next.group = c3_reg.group;
        res_next.hit   = c3_reg.cand && (rsq < cutoff_sq);
        res_next.tag   = c3_reg.tag;
        res_next.dx    = s3x_reg;
        res_next.dy    = s3y_reg;
        res_next.dz    = s3z_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg.valid  <= 1'b0;
            c2_reg.valid  <= 1'b0;
            c3_reg.valid  <= 1'b0;
            res_reg.valid <= 1'b0;
        end else if (adv) begin
            c1_reg.valid  <= in_beat;
            c2_reg.valid  <= c1_reg.valid;
            c3_reg.valid  <= c2_reg.valid;
            res_reg.valid <= res_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg.last  <= last_cand;
            c1_reg.group <= in_group;
            c1_reg.cand  <= cand_valid;
            c1_reg.tag   <= cand_tag;
            d1x_reg      <= d1x_next;
            d1y_reg      <= d1y_next;
            d1z_reg      <= d1z_next;

            c2_reg.last  <= c1_reg.last;
            c2_reg.group <= c1_reg.group;
            c2_reg.cand  <= c1_reg.cand;
            c2_reg.tag   <= c1_reg.tag;
            sqx_reg      <= sqx_next;
            sqy_reg      <= sqy_next;
            sqz_reg      <= sqz_next;
            s2x_reg      <= s2x_next;
            s2y_reg      <= s2y_next;
            s2z_reg      <= s2z_next;

            c3_reg.last  <= c2_reg.last;
            c3_reg.group <= c2_reg.group;
            c3_reg.cand  <= c2_reg.cand;
            c3_reg.tag   <= c2_reg.tag;
            sxy_reg      <= sxy_next;
            sz3_reg      <= sqz_reg;
            s3x_reg      <= s2x_reg;
            s3y_reg      <= s2y_reg;
            s3z_reg      <= s2z_reg;

            res_reg.last  <= res_next.last;
            res_reg.group <= res_next.group;
            res_reg.hit   <= res_next.hit;
            res_reg.tag   <= res_next.tag;
            res_reg.dx    <= res_next.dx;
            res_reg.dy    <= res_next.dy;
            res_reg.dz    <= res_next.dz;
        end
    end

    assign res = res_reg;

endmodule

[rtl/cnc_slot_cell.sv]
module cnc_slot_cell
    import cnc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  logic       clear,
    input  logic       prev_occ,
    input  nbr_entry_t push_entry,
    output cell_view_t view
);

    logic       occ_reg, occ_next;
    nbr_entry_t entry_reg, entry_next;
    logic       take;

    // the first free cell in the row takes the new neighbor
    always_comb begin
        take       = push && !occ_reg && prev_occ;
        occ_next   = occ_reg || take;
        entry_next = take ? push_entry : entry_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= clear ? 1'b0 : occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign view.occ        = occ_reg;
    assign view.occ_view   = occ_next;
    assign view.entry_view = entry_next;

endmodule

[rtl/cnc_out_cell.sv]
module cnc_out_cell
    import cnc_pkg::*;
(
    input  logic       aclk,
    input  logic       load,
    input  logic       shift,
    input  logic       disp_mode,
    input  cell_view_t src,
    input  slot_t      from_right,
    output slot_t      slot
);

    slot_t slot_reg, slot_next, fmt;

    always_comb begin
        fmt = EMPTY_SLOT;
        if (src.occ_view) begin
            fmt.tag = {1'b0, src.entry_view.tag};
            if (disp_mode) begin
                fmt.dx = src.entry_view.dx;
                fmt.dy = src.entry_view.dy;
                fmt.dz = src.entry_view.dz;
            end
        end
        if (load) begin
            slot_next = fmt;
        end else if (shift) begin
            slot_next = from_right;
        end else begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

[rtl/cutoff_neighbor_collect_top.sv]
// The first slot of a list is offered once the beat of the atom's last item has passed the
//   four pipeline stages (delta, square, partial sum, sum and compare) and loaded the output row.
// Throughput: one candidate per cycle; a list leaves as 16 beats, one per cycle while m_tready
//   is high, from a shift row that reloads as its final slot goes out, so input stalls only when
//   a list ends before the previous one has drained.
// Reset (aresetn low, synchronous): pipeline, slot occupancy, overflow and output count clear;
//   cutoff_squared and output_mode return to zero.
module cutoff_neighbor_collect_top
    import cnc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // center_x, center_y, center_z, cand_x, cand_y, cand_z, cand_tag, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // cand_valid, in_group
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // slot_index, slot_tag, slot_dx, slot_dy, slot_dz, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    // overflowed
    output logic                  m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_wr_en,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [SQ_W-1:0]   cutoff_sq_reg;
    logic              out_mode_reg;
    logic              ovf_reg, ovf_next;
    logic              out_ovf_reg;
    logic [OCNT_W-1:0] out_cnt_reg, out_cnt_next;

    cand_res_t  res;
    logic       adv, fire, full, push, end_atom, load, pop, out_free;
    nbr_entry_t push_entry;
    cell_view_t views [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] occ_vec;
    slot_t      slots [OUT_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_sq_reg <= '0;
            out_mode_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CUTOFF_SQ:   cutoff_sq_reg <= cfg_wdata;
                CFG_OUTPUT_MODE: out_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    cnc_dist_pipe u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_beat    (s_tvalid && s_tready),
        .center_x   (s_tdata[31:0]),
        .center_y   (s_tdata[63:32]),
        .center_z   (s_tdata[95:64]),
        .cand_x     (s_tdata[127:96]),
        .cand_y     (s_tdata[159:128]),
        .cand_z     (s_tdata[191:160]),
        .cand_tag   (s_tdata[222:192]),
        .cand_valid (s_tuser[0]),
        .in_group   (s_tuser[1]),
        .last_cand  (s_tlast),
        .cutoff_sq  (cutoff_sq_reg),
        .res        (res)
    );

    // the output row is free when empty or when its final slot leaves this cycle
    assign out_free = (out_cnt_reg == '0) || ((out_cnt_reg == OCNT_W'(1)) && m_tready);
    // hold the whole pipeline while a finished list waits for the output row
    assign adv      = !(res.valid && res.last && res.group && !out_free);
    assign s_tready = adv;

    assign fire     = res.valid && adv;
    assign full     = occ_vec[MAX_NEIGHBORS-1];
    assign push     = fire && res.hit && !ovf_reg && !full;
    assign ovf_next = ovf_reg || (fire && res.hit && full);
    assign end_atom = fire && res.last;
    assign load     = end_atom && res.group;
    assign pop      = m_tvalid && m_tready;

    assign push_entry.tag = res.tag;
    assign push_entry.dx  = res.dx;
    assign push_entry.dy  = res.dy;
    assign push_entry.dz  = res.dz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg <= 1'b0;
        end else begin
            ovf_reg <= end_atom ? 1'b0 : ovf_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_NEIGHBORS; k++) begin : g_coll
            logic prev_occ;
            if (k == 0) begin : g_first
                assign prev_occ = 1'b1;
            end else begin : g_rest
                assign prev_occ = views[k-1].occ;
            end
            cnc_slot_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .push       (push),
                .clear      (end_atom),
                .prev_occ   (prev_occ),
                .push_entry (push_entry),
                .view       (views[k])
            );
            assign occ_vec[k] = views[k].occ;
        end

        for (k = 0; k < OUT_SLOTS; k++) begin : g_out
            slot_t right;
            if (k == OUT_SLOTS - 1) begin : g_end
                assign right = EMPTY_SLOT;
            end else begin : g_mid
                assign right = slots[k+1];
            end
            cnc_out_cell u_out (
                .aclk       (aclk),
                .load       (load),
                .shift      (pop),
                .disp_mode  (out_mode_reg),
                .src        (views[k]),
                .from_right (right),
                .slot       (slots[k])
            );
        end
    endgenerate

    always_comb begin
        out_cnt_next = out_cnt_reg;
        if (load) begin
            out_cnt_next = OCNT_W'(OUT_SLOTS);
        end else if (pop) begin
            out_cnt_next = out_cnt_reg - OCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= '0;
        end else begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_ovf_reg <= ovf_next;
        end
    end

    assign m_tvalid = (out_cnt_reg != '0);
    assign m_tlast  = (out_cnt_reg == OCNT_W'(1));
    assign m_tuser  = out_ovf_reg;
    assign m_tdata  = {4'b0000, slots[0].dz, slots[0].dy, slots[0].dx, slots[0].tag,
                       SLOT_IDX_W'(OCNT_W'(OUT_SLOTS) - out_cnt_reg)};

    // occupied cells stay packed from the low end
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ_vec >> 1) & ~occ_vec) == '0)
        else $error("collect row has a hole");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> full)
        else $error("overflow set while slots remain free");

    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (out_cnt_reg == '0 || (out_cnt_reg == OCNT_W'(1) && m_tready)))
        else $error("output row reloaded while slots still pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (res.valid && res.last && res.group && m_tvalid))
        else $error("input stalled without a pending list");

    assert property (@(posedge aclk) disable iff (!aresetn)
        end_atom |=> (occ_vec == '0 && !ovf_reg))
        else $error("atom state not cleared at end of list");

endmodule
